// ===== design/lser_pkg.sv =====
// Shared types and constants for the sequenced event ring.
package lser_pkg;

	// Default ring depth
	localparam int DEPTH_DEF = 256;

	// Item modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Event record as held in the payload memory
	typedef struct packed {
		logic [31:0] instance_id;
		logic [31:0] owner_id;
		logic [31:0] string_value;
		logic [63:0] context_addr;
		logic        round_flag;
		logic [7:0]  event_kind;
		logic [31:0] timestamp;
	} rec_t;

endpackage

// ===== design/lossy_sequenced_event_ring.sv =====
// Top level of the overwrite event ring with per-slot sequence stamps.
// Push: result strobe in the cycle after the transfer; pushes can follow every cycle
// while idle. Pop: the result strobe follows the READ and UPD states; busy stays high
// through the stamp compare and drop count update, so no new item is taken until the
// pop result is out. Reset clears the sequence pointers, drop count and fill flag; the
// memories are not swept, slots past the fill flag read as empty. Results cannot be stalled.
module lossy_sequenced_event_ring #(
	parameter int DEPTH = lser_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic signed [31:0] instance_id,
	input  logic [31:0]        owner_id,
	input  logic [31:0]        string_value,
	input  logic [63:0]        context_addr,
	input  logic [7:0]         event_kind,
	input  logic               round_flag,
	input  logic [31:0]        timestamp,
	output logic               done,
	output logic               got_record,
	output logic [63:0]        out_seq,
	output logic signed [31:0] out_instance,
	output logic [31:0]        out_owner,
	output logic [31:0]        out_string,
	output logic [63:0]        out_addr,
	output logic [7:0]         out_kind,
	output logic               out_round,
	output logic [31:0]        out_time,
	output logic [63:0]        dropped_now,
	output logic [63:0]        dropped_total
);
	import lser_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_UPD} state_t;

	// Memories
	logic [63:0] stamp_mem [DEPTH];
	rec_t        rec_mem   [DEPTH];

	state_t      state_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_idx_q;
	logic        filled_q;
	logic [63:0] wseq_q;      // next stamp to write (write_seq + 1)
	logic [63:0] exp_q;       // expected stamp at the read slot (read_seq + 1)
	logic [63:0] drop_cnt_q;

	logic [63:0] stamp_rd_q;
	rec_t        rec_rd_q;
	logic        slot_ok_q;

	logic        ge_s2;
	logic [63:0] drops_s2;
	logic [63:0] seq_s2;
	logic [63:0] nexp_s2;

	logic        done_q;
	logic        got_q;
	logic [63:0] seq_q;
	rec_t        rec_q;
	logic [63:0] drop_now_q;
	logic [63:0] drop_tot_q;

	logic        accept;
	logic        push_go;
	logic        pop_go;
	logic [63:0] stamp_eff;
	rec_t        push_rec;

	assign accept  = start && !busy;
	assign push_go = accept && (mode == MODE_PUSH);
	assign pop_go  = accept && (mode == MODE_POP);
	assign busy    = (state_q != ST_IDLE);

	// Build the record to store
	always_comb begin
		push_rec.instance_id  = instance_id;
		push_rec.owner_id     = owner_id;
		push_rec.string_value = string_value;
		push_rec.context_addr = context_addr;
		push_rec.round_flag   = round_flag;
		push_rec.event_kind   = event_kind;
		push_rec.timestamp    = timestamp;
	end

	// Write on push, read the slot at the read pointer on pop
	always_ff @(posedge clk) begin
		if (push_go) begin
			stamp_mem[wr_idx_q] <= wseq_q;
			rec_mem[wr_idx_q]   <= push_rec;
		end
		if (pop_go) begin
			stamp_rd_q <= stamp_mem[rd_idx_q];
			rec_rd_q   <= rec_mem[rd_idx_q];
		end
	end

	// Unwritten slots carry a zero stamp
	assign stamp_eff = slot_ok_q ? stamp_rd_q : 64'd0;

	// Stamp compare stage
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			ge_s2    <= (stamp_eff >= exp_q);
			drops_s2 <= (stamp_eff > exp_q) ? (stamp_eff - exp_q) : 64'd0;
			seq_s2   <= stamp_eff - 64'd1;
			nexp_s2  <= stamp_eff + 64'd1;
		end
	end

	// Sequencer, pointers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			filled_q   <= 1'b0;
			wseq_q     <= 64'd1;
			exp_q      <= 64'd1;
			drop_cnt_q <= 64'd0;
			slot_ok_q  <= 1'b0;
			done_q     <= 1'b0;
			got_q      <= 1'b0;
			seq_q      <= 64'd0;
			rec_q      <= '0;
			drop_now_q <= 64'd0;
			drop_tot_q <= 64'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (push_go) begin
						wr_idx_q   <= (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + AW'(1);
						if (wr_idx_q == LAST_IDX) begin
							filled_q <= 1'b1;
						end
						wseq_q     <= wseq_q + 64'd1;
						done_q     <= 1'b1;
						got_q      <= 1'b0;
						seq_q      <= 64'd0;
						rec_q      <= '0;
						drop_now_q <= 64'd0;
						drop_tot_q <= drop_cnt_q;
					end else if (pop_go) begin
						slot_ok_q <= filled_q || (rd_idx_q < wr_idx_q);
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q    <= ST_IDLE;
					done_q     <= 1'b1;
					got_q      <= ge_s2;
					seq_q      <= ge_s2 ? seq_s2 : 64'd0;
					rec_q      <= ge_s2 ? rec_rd_q : '0;
					drop_now_q <= drops_s2;
					drop_tot_q <= drop_cnt_q + drops_s2;
					// advance the read position past the returned record
					if (ge_s2) begin
						drop_cnt_q <= drop_cnt_q + drops_s2;
						exp_q      <= nexp_s2;
						rd_idx_q   <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive result ports
	assign done          = done_q;
	assign got_record    = got_q;
	assign out_seq       = seq_q;
	assign out_instance  = $signed(rec_q.instance_id);
	assign out_owner     = rec_q.owner_id;
	assign out_string    = rec_q.string_value;
	assign out_addr      = rec_q.context_addr;
	assign out_kind      = rec_q.event_kind;
	assign out_round     = rec_q.round_flag;
	assign out_time      = rec_q.timestamp;
	assign dropped_now   = drop_now_q;
	assign dropped_total = drop_tot_q;

endmodule

// ===== design/lser_checker.sv =====
// Port-level checker for the sequenced event ring, bound to the top level.
module lser_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        mode,
	input logic        done,
	input logic        got_record,
	input logic [63:0] out_seq,
	input logic [63:0] dropped_now
);
	import lser_pkg::*;

	// A pop transfer holds off new items while the slot is read
	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_POP |=> busy)
		else $error("pop transfer not followed by busy");

	// A push transfer yields its result in the next cycle
	a_push_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_PUSH |=> done)
		else $error("push result missing");

	// A pop transfer yields its result once the READ and UPD states have passed
	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_POP |-> ##3 done)
		else $error("pop result missing");

	// An empty result carries no sequence and no drops
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !got_record |-> out_seq == 64'd0 && dropped_now == 64'd0)
		else $error("empty result carries data");

	// Every result traces back to a transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $past(start && !busy, 3))
		else $error("result without transfer");

endmodule

bind lossy_sequenced_event_ring lser_checker u_lser_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.mode        (mode),
	.done        (done),
	.got_record  (got_record),
	.out_seq     (out_seq),
	.dropped_now (dropped_now)
);
